@@ src/tlc_pkg.sv @@
// Shared types and constants for the transpose lookup cache.
package tlc_pkg;

  localparam int unsigned Entries = 8;
  localparam int unsigned CntW    = $clog2(Entries + 1);
  localparam int unsigned TagW    = 64;
  localparam int unsigned PayW    = 32;
  localparam int unsigned SlotW   = 3;

  typedef struct packed {
    logic [TagW-1:0] address;
    logic [PayW-1:0] fill_value;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [PayW-1:0]  value;
    logic [SlotW-1:0] slot;
  } out_item_t;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [PayW-1:0] payload;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2
  } cell_op_e;

endpackage

@@ src/tlc_cell.sv @@
// One cache slot: holds a tag and payload, compares, and loads from a neighbour.
module tlc_cell (
  input  logic                        clk_i,
  input  logic                        valid_i,
  input  logic [tlc_pkg::TagW-1:0]    lookup_i,
  input  tlc_pkg::cell_op_e           op_i,
  input  tlc_pkg::entry_t             left_i,
  input  tlc_pkg::entry_t             right_i,
  output tlc_pkg::entry_t             entry_o,
  output logic                        match_o
);

  tlc_pkg::entry_t entry_q, entry_d;

  always_comb begin
    case (op_i)
      tlc_pkg::OP_LEFT:  entry_d = left_i;
      tlc_pkg::OP_RIGHT: entry_d = right_i;
      default:           entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign match_o = valid_i && (entry_q.tag == lookup_i);
  assign entry_o = entry_q;

endmodule

@@ src/transpose_lookup_cache.sv @@
// Top level: chain of cache slots with transposition on hit and shift-in on miss.
//
//   channel | signals                          | payload
//   --------+----------------------------------+----------------------------
//   input   | in_valid_i / in_ready_o          | in_data_i  (address, fill)
//   output  | out_valid_o / out_ready_i        | out_data_o (hit, value, slot)
//
// An item is looked up and the slots updated in the cycle it transfers; its
// result sits in the output register from the next cycle, so one item per cycle while results are taken.
// The single compare-and-move pass over all slots sets that figure.
// Reset empties the cache (fill count to zero); slot contents are not cleared.
// A stalled output holds the result and blocks input until it is taken.
module transpose_lookup_cache (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tlc_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tlc_pkg::out_item_t out_data_o
);

  tlc_pkg::entry_t                 entries [tlc_pkg::Entries];
  tlc_pkg::cell_op_e               ops     [tlc_pkg::Entries];
  logic [tlc_pkg::Entries-1:0]     match;
  logic [tlc_pkg::Entries-1:0]     valid;
  logic [tlc_pkg::CntW-1:0]        count_q, count_d;
  logic                            out_valid_q, out_valid_d;
  tlc_pkg::out_item_t              out_q, out_d;
  logic                            in_fire;
  logic                            hit;
  tlc_pkg::entry_t                 in_entry;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign hit        = |match;
  assign in_entry   = '{tag: in_data_i.address, payload: in_data_i.fill_value};

  for (genvar g = 0; g < tlc_pkg::Entries; g++) begin : g_cell
    tlc_pkg::entry_t left, right;

    assign valid[g] = count_q > tlc_pkg::CntW'(g);

    if (g == 0) begin : g_first
      assign left = in_entry;
    end else begin : g_rest
      assign left = entries[g-1];
    end

    if (g == tlc_pkg::Entries - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = entries[g+1];
    end

    tlc_cell u_cell (
      .clk_i    (clk_i),
      .valid_i  (valid[g]),
      .lookup_i (in_data_i.address),
      .op_i     (ops[g]),
      .left_i   (left),
      .right_i  (right),
      .entry_o  (entries[g]),
      .match_o  (match[g])
    );
  end

  // Miss: shift every slot down. Hit at slot i > 0: swap slots i and i-1.
  always_comb begin
    for (int i = 0; i < tlc_pkg::Entries; i++) begin
      ops[i] = tlc_pkg::OP_HOLD;
      if (in_fire) begin
        if (!hit) begin
          ops[i] = tlc_pkg::OP_LEFT;
        end else if (i > 0 && match[i]) begin
          ops[i] = tlc_pkg::OP_LEFT;
        end else if (i < tlc_pkg::Entries - 1 && match[(i + 1) % tlc_pkg::Entries]) begin
          ops[i] = tlc_pkg::OP_RIGHT;
        end
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d  = 1'b1;
      out_d.hit    = hit;
      out_d.value  = in_data_i.fill_value;
      out_d.slot   = '0;
      if (hit) begin
        out_d.value = '0;
        for (int i = 0; i < tlc_pkg::Entries; i++) begin
          if (match[i]) begin
            out_d.value = out_d.value | entries[i].payload;
            out_d.slot  = out_d.slot | tlc_pkg::SlotW'(i);
          end
        end
      end else if (count_q != tlc_pkg::CntW'(tlc_pkg::Entries)) begin
        count_d = count_q + tlc_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_tag_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> $onehot0(match))
    else $error("address matches more than one slot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tlc_pkg::CntW'(tlc_pkg::Entries))
    else $error("fill count beyond cache depth");

  a_miss_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !hit && count_q != tlc_pkg::CntW'(tlc_pkg::Entries))
      |=> count_q == $past(count_q) + tlc_pkg::CntW'(1))
    else $error("miss did not grow fill count");

  a_hit_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && hit) |=> count_q == $past(count_q))
    else $error("hit changed fill count");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q && out_q.hit == $past(hit))
    else $error("result not registered after transfer");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the transpose lookup cache: predicted lookups against the block's results.
`timescale 1ns / 100ps

module tb;

  localparam int QuietLimit = 5000;

  // Mirror of the cache list plus the queue of lookup results still to come back.
  class lookup_scoreboard;
    logic [tlc_pkg::TagW-1:0] tags [tlc_pkg::Entries];
    logic [tlc_pkg::PayW-1:0] pays [tlc_pkg::Entries];
    int                       filled;
    tlc_pkg::out_item_t       lookup_q [$];
    int                       fail_count;

    function new();
      filled     = 0;
      fail_count = 0;
    endfunction

    function void report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
    endfunction

    function void note_lookup(tlc_pkg::in_item_t item);
      tlc_pkg::out_item_t       res;
      logic [tlc_pkg::PayW-1:0] pay;
      int                       found;
      found = -1;
      for (int i = 0; i < filled; i++) begin
        if (found < 0 && tags[i] == item.address) found = i;
      end
      if (found >= 0) begin
        pay = pays[found];
        // transpose with the neighbour nearer the head
        if (found > 0) begin
          tags[found]     = tags[found-1];
          pays[found]     = pays[found-1];
          tags[found-1]   = item.address;
          pays[found-1]   = pay;
        end
        res.hit   = 1'b1;
        res.value = pay;
        res.slot  = found[tlc_pkg::SlotW-1:0];
      end else begin
        if (filled < tlc_pkg::Entries) filled++;
        // shift the list down; the tail entry drops out when full
        for (int i = filled - 1; i > 0; i--) begin
          tags[i] = tags[i-1];
          pays[i] = pays[i-1];
        end
        tags[0]   = item.address;
        pays[0]   = item.fill_value;
        res.hit   = 1'b0;
        res.value = item.fill_value;
        res.slot  = '0;
      end
      lookup_q.push_back(res);
    endfunction

    function void check_result(tlc_pkg::out_item_t got);
      tlc_pkg::out_item_t want;
      if (lookup_q.size() == 0) begin
        report($sformatf("result with nothing outstanding: hit %b value %h slot %0d",
                         got.hit, got.value, got.slot));
        return;
      end
      want = lookup_q.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit %b, predicted %b", got.hit, want.hit));
      if (got.value !== want.value)
        report($sformatf("value %h, predicted %h", got.value, want.value));
      if (got.slot !== want.slot)
        report($sformatf("slot %0d, predicted %0d", got.slot, want.slot));
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  tlc_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  tlc_pkg::out_item_t out_data_o;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  lookup_scoreboard sb = new();

  transpose_lookup_cache u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sample both channels on the edge at which a transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_lookup(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [tlc_pkg::TagW-1:0] rand_addr();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Keep valid high between back-to-back items; drop it only while idling.
  task automatic send_lookup(logic [tlc_pkg::TagW-1:0] addr, logic [tlc_pkg::PayW-1:0] fill);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    in_data_i.address    <= addr;
    in_data_i.fill_value <= fill;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.lookup_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_lookup('0, '0);                   // miss into an empty cache
    send_lookup('1, '1);
    send_lookup('0, 32'h1234_5678);        // hit below the head, fill ignored
    send_lookup('0, '1);                   // hit at the head: nothing moves
    for (int k = 1; k <= 6; k++)
      send_lookup({32'hA5A5_0000 | k, 32'h5A5A_5A5A ^ k}, 32'hC0DE_0000 + k);
    send_lookup('1, '0);                   // hit in the last slot
    send_lookup(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);  // full: tail drops
    send_lookup(64'h5555_5555_5555_5555, 32'h5555_5555);
    send_lookup('0, 32'h0F0F_0F0F);        // dropped tag comes back as a miss
    send_lookup('0, '0);                   // repeated address
    send_lookup({32'hA5A5_0003, 32'h5A5A_5A59}, '1);
    send_lookup({32'hA5A5_0003, 32'h5A5A_5A59}, '0);
  endtask

  task automatic run_random(int count, int hold_at);
    logic [tlc_pkg::TagW-1:0] pool [16];
    int                       pool_size;
    logic [tlc_pkg::TagW-1:0] addr;
    logic [tlc_pkg::PayW-1:0] fill;
    pool_size = 1;
    for (int k = 0; k < count; k++) begin
      // fresh working set now and then: small ones give deep hit runs,
      // large ones keep the cache evicting
      if (k % 40 == 0) begin
        pool_size = $urandom_range(3, 16);
        for (int j = 0; j < 16; j++) pool[j] = rand_addr();
      end
      if (k == hold_at) hold_cycles = 300;
      if ($urandom_range(99) < 85) addr = pool[$urandom_range(pool_size - 1)];
      else addr = rand_addr();
      case ($urandom_range(9))
        0:       fill = '0;
        1:       fill = '1;
        default: fill = $urandom;
      endcase
      send_lookup(addr, fill);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 63; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 8;  stall_pct = 8;  end
      endcase
      run_random(250, (phase == 0) ? 120 : -1);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.lookup_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.lookup_q.size()));
    if (sb.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
